### rtl/ntds_pkg.sv
// ----------------------------------------------------------------------------
// ntds_pkg - shared types and constants of the time display sequencer
// Command codes, register indexes, controller states and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ntds_pkg;

   // input item commands
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ON     = 2'd1;
   localparam logic [1:0] CMD_OFF    = 2'd2;

   // register indexes on the csr port
   localparam logic [2:0] REG_DAY_DUTY     = 3'd0;
   localparam logic [2:0] REG_NIGHT_DUTY   = 3'd1;
   localparam logic [2:0] REG_OFF_DUTY     = 3'd2;
   localparam logic [2:0] REG_DAY_START    = 3'd3;
   localparam logic [2:0] REG_NIGHT_START  = 3'd4;
   localparam logic [2:0] REG_ROLL_STEP    = 3'd5;
   localparam logic [2:0] REG_HOUR_HOLD    = 3'd6;
   localparam logic [2:0] REG_SECONDS_STEP = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // time constants
   localparam logic [10:0] MINUTES_PER_DAY   = 11'd1440;
   localparam logic [15:0] MS_PER_MINUTE     = 16'd60000;
   localparam logic [9:0]  MS_PER_SECOND     = 10'd1000;
   localparam logic signed [7:0] HOUR_ROLL_STEPS   = 8'sd100;
   localparam logic signed [7:0] MINUTE_ROLL_STEPS = 8'sd10;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUND,
      ST_LWAIT,
      ST_STEP,
      ST_DIV,
      ST_SWAIT,
      ST_DONE
   } ntds_state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic bound;
      logic lwait;
      logic step;
      logic div_step;
      logic swait;
      logic out_load;
   } ntds_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic div_needed;
      logic div_last;
      logic have_result;
   } ntds_status_type;

endpackage

### rtl/ntds_if.sv
// ----------------------------------------------------------------------------
// ntds_if - item channels of the time display sequencer
// Request channel carries commands and time of day, response channel carries
// tube patterns and duty values.
// ----------------------------------------------------------------------------
interface ntds_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [4:0] clock_hour;
   logic [5:0] clock_minute;
   logic [5:0] clock_second;

   modport source (output valid, output cmd, output clock_hour, output clock_minute,
                   output clock_second, input ready);
   modport sink   (input valid, input cmd, input clock_hour, input clock_minute,
                   input clock_second, output ready);
endinterface

interface ntds_rsp_if;
   logic        valid;
   logic        ready;
   logic        tube_valid;
   logic [31:0] tube_pattern;
   logic        duty_valid;
   logic [7:0]  duty;

   modport source (output valid, output tube_valid, output tube_pattern,
                   output duty_valid, output duty, input ready);
   modport sink   (input valid, input tube_valid, input tube_pattern,
                   input duty_valid, input duty, output ready);
endinterface

### rtl/ntds_ctrl.sv
// ----------------------------------------------------------------------------
// ntds_ctrl - sequencing controller
// Walks one tick through brightness, animation and hold phases and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module ntds_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ntds_pkg::ntds_status_type status,
   output ntds_pkg::ntds_cmd_type    cmd
);

   ntds_pkg::ntds_state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntds_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ntds_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.is_tick) state_in = ntds_pkg::ST_BOUND;
            end
         end
         ntds_pkg::ST_BOUND: begin
            cmd.bound = 1'b1;
            state_in  = ntds_pkg::ST_LWAIT;
         end
         ntds_pkg::ST_LWAIT: begin
            cmd.lwait = 1'b1;
            state_in  = ntds_pkg::ST_STEP;
         end
         ntds_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            state_in = status.div_needed ? ntds_pkg::ST_DIV : ntds_pkg::ST_DONE;
         end
         ntds_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ntds_pkg::ST_SWAIT;
         end
         ntds_pkg::ST_SWAIT: begin
            cmd.swait = 1'b1;
            state_in  = ntds_pkg::ST_DONE;
         end
         ntds_pkg::ST_DONE: begin
            priority if (!status.have_result) begin
               state_in = ntds_pkg::ST_IDLE;
            end else if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ntds_pkg::ST_IDLE;
            end else begin
               state_in = ntds_pkg::ST_DONE;
            end
         end
         default: state_in = ntds_pkg::ST_IDLE;
      endcase
   end

   // output register occupancy
   always_comb begin
      priority if (cmd.out_load) out_valid_in = 1'b1;
      else if (rsp_ready)        out_valid_in = 1'b0;
      else                       out_valid_in = out_valid_ff;
   end

   assign req_ready = (state_ff == ntds_pkg::ST_IDLE);
   assign rsp_valid = out_valid_ff;

   // a tick always starts with the brightness phase
   a_tick_to_bound: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.is_tick) |=> state_ff == ntds_pkg::ST_BOUND)
      else $error("tick did not enter brightness phase");

   // hold time is computed only after the remainder iteration
   a_swait_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ntds_pkg::ST_SWAIT |-> $past(state_ff) == ntds_pkg::ST_DIV)
      else $error("hold wait without remainder iteration");

   // a new item never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("output register overwritten");

endmodule

### rtl/ntds_dp.sv
// ----------------------------------------------------------------------------
// ntds_dp - sequencer datapath
// Holds registers, waits, animation digits and the remainder unit; acts on
// the commands of the controller.
// ----------------------------------------------------------------------------
module ntds_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [ntds_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ntds_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   input  logic [1:0]                             req_cmd,
   input  logic [4:0]                             req_hour,
   input  logic [5:0]                             req_minute,
   input  logic [5:0]                             req_second,
   input  ntds_pkg::ntds_cmd_type                 cmd,
   output ntds_pkg::ntds_status_type              status,
   output logic                                   rsp_tube_valid,
   output logic [31:0]                            rsp_tube_pattern,
   output logic                                   rsp_duty_valid,
   output logic [7:0]                             rsp_duty
);

   localparam logic signed [17:0] STEP_WAIT_MIN  = {1'b1, 17'd0};
   localparam logic signed [27:0] LEVEL_WAIT_MIN = {1'b1, 27'd0};
   localparam logic [2:0]         DIV_TOP_BIT    = 3'd5;

   // one-hot socket of a digit
   function automatic logic [15:0] socket_of(input logic [3:0] d);
      logic [15:0] s;
      unique case (d)
         4'd0:    s = 16'h0020;
         4'd1:    s = 16'h0400;
         4'd2:    s = 16'h0040;
         4'd3:    s = 16'h8000;
         4'd4:    s = 16'h0080;
         4'd5:    s = 16'h1000;
         4'd6:    s = 16'h0010;
         4'd7:    s = 16'h4000;
         4'd8:    s = 16'h0200;
         4'd9:    s = 16'h0800;
         default: s = 16'h0000;
      endcase
      return s;
   endfunction

   // minutes to a boundary, 1 to a whole day
   function automatic logic [10:0] minutes_until(input logic [10:0] start,
                                                 input logic [10:0] now);
      logic [10:0] s;
      logic [11:0] d;
      s = (start >= ntds_pkg::MINUTES_PER_DAY) ? start - ntds_pkg::MINUTES_PER_DAY : start;
      d = {1'b0, s} + {1'b0, ntds_pkg::MINUTES_PER_DAY} - {1'b0, now};
      if (d >= {1'b0, ntds_pkg::MINUTES_PER_DAY}) d = d - {1'b0, ntds_pkg::MINUTES_PER_DAY};
      return (d == 12'd0) ? ntds_pkg::MINUTES_PER_DAY : d[10:0];
   endfunction

   // tens digit of a minute up to 63
   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [3:0] t;
      priority if (v >= 6'd60) t = 4'd6;
      else if (v >= 6'd50)     t = 4'd5;
      else if (v >= 6'd40)     t = 4'd4;
      else if (v >= 6'd30)     t = 4'd3;
      else if (v >= 6'd20)     t = 4'd2;
      else if (v >= 6'd10)     t = 4'd1;
      else                     t = 4'd0;
      return t;
   endfunction

   // configuration registers
   logic [7:0]  day_duty_ff, night_duty_ff, off_duty_ff, roll_step_ff;
   logic [10:0] day_start_ff, night_start_ff;
   logic [15:0] hour_hold_ff;
   logic [5:0]  seconds_step_ff;

   // state
   logic signed [17:0] step_wait_ff, step_wait_in;
   logic signed [27:0] level_wait_ff, level_wait_in;
   logic [3:0]         tens_ff, tens_in, ones_ff, ones_in;
   logic signed [7:0]  steps_left_ff, steps_left_in;
   logic               rolling_ff, rolling_in;
   logic               hour_shown_ff, hour_shown_in;
   logic               tubes_on_ff, tubes_on_in;

   // per-item working registers
   logic [10:0] now_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff, second_ff;
   logic [10:0] mins_ff, mins_in;
   logic        tv_ff, tv_in, dv_ff, dv_in;
   logic [31:0] pattern_ff, pattern_in;
   logic [7:0]  duty_ff, duty_in;
   logic [5:0]  rem_ff, rem_in;
   logic [2:0]  div_cnt_ff, div_cnt_in;

   // combinational helpers
   logic [10:0] to_day, to_night;
   logic        night;
   logic [5:0]  modulus;
   logic [6:0]  rem_shift;
   logic [4:0]  hour12;
   logic [26:0] level_prod;
   logic [15:0] hold_prod;
   logic [5:0]  hold_secs;
   logic [3:0]  min_tens;
   logic        step_neg, level_neg, roll_end;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         day_duty_ff     <= 8'd0;
         night_duty_ff   <= 8'd220;
         off_duty_ff     <= 8'd255;
         day_start_ff    <= 11'd360;
         night_start_ff  <= 11'd1260;
         roll_step_ff    <= 8'd15;
         hour_hold_ff    <= 16'd1000;
         seconds_step_ff <= 6'd10;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ntds_pkg::REG_DAY_DUTY:     day_duty_ff     <= csr_wr_data[7:0];
            ntds_pkg::REG_NIGHT_DUTY:   night_duty_ff   <= csr_wr_data[7:0];
            ntds_pkg::REG_OFF_DUTY:     off_duty_ff     <= csr_wr_data[7:0];
            ntds_pkg::REG_DAY_START:    day_start_ff    <= csr_wr_data[10:0];
            ntds_pkg::REG_NIGHT_START:  night_start_ff  <= csr_wr_data[10:0];
            ntds_pkg::REG_ROLL_STEP:    roll_step_ff    <= csr_wr_data[7:0];
            ntds_pkg::REG_HOUR_HOLD:    hour_hold_ff    <= csr_wr_data[15:0];
            ntds_pkg::REG_SECONDS_STEP: seconds_step_ff <= csr_wr_data[5:0];
            default: ;
         endcase
      end
   end

   // brightness selection
   assign to_day     = minutes_until(day_start_ff, now_ff);
   assign to_night   = minutes_until(night_start_ff, now_ff);
   assign night      = to_day < to_night;
   assign level_prod = 27'(mins_ff) * 27'(ntds_pkg::MS_PER_MINUTE);
   assign step_neg   = step_wait_ff[17];
   assign level_neg  = level_wait_ff[27];

   // digits of the shown values
   always_comb begin
      priority if (hour_ff >= 5'd24) hour12 = hour_ff - 5'd24;
      else if (hour_ff >= 5'd12)     hour12 = hour_ff - 5'd12;
      else                           hour12 = hour_ff;
      if (hour12 == 5'd0) hour12 = 5'd12;
   end
   assign min_tens = tens_of(minute_ff);

   // remainder unit, one dividend bit a step
   assign modulus   = (seconds_step_ff == 6'd0) ? 6'd1 : seconds_step_ff;
   assign rem_shift = {rem_ff, second_ff[div_cnt_ff]};
   assign hold_secs = modulus - rem_ff;
   assign hold_prod = 16'(hold_secs) * 16'(ntds_pkg::MS_PER_SECOND);
   assign roll_end  = rolling_ff && !(steps_left_ff > 8'sd0);

   // next state
   always_comb begin
      step_wait_in  = step_wait_ff;
      level_wait_in = level_wait_ff;
      tens_in       = tens_ff;
      ones_in       = ones_ff;
      steps_left_in = steps_left_ff;
      rolling_in    = rolling_ff;
      hour_shown_in = hour_shown_ff;
      tubes_on_in   = tubes_on_ff;
      mins_in       = mins_ff;
      tv_in         = tv_ff;
      dv_in         = dv_ff;
      pattern_in    = pattern_ff;
      duty_in       = duty_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;

      // item taken: commands act at once, ticks count down the waits
      if (cmd.take) begin
         if (req_cmd == ntds_pkg::CMD_ON || req_cmd == ntds_pkg::CMD_OFF) begin
            level_wait_in = '0;
            tubes_on_in   = (req_cmd == ntds_pkg::CMD_ON);
         end else if (req_cmd == ntds_pkg::CMD_TICK) begin
            if (step_wait_ff != STEP_WAIT_MIN)   step_wait_in  = step_wait_ff - 18'sd1;
            if (level_wait_ff != LEVEL_WAIT_MIN) level_wait_in = level_wait_ff - 28'sd1;
            tv_in      = 1'b0;
            dv_in      = 1'b0;
            pattern_in = '0;
            duty_in    = '0;
         end
      end

      // duty at brightness timer expiry
      if (cmd.bound && !rolling_ff && level_neg) begin
         dv_in   = 1'b1;
         mins_in = night ? to_day : to_night;
         duty_in = tubes_on_ff ? (night ? night_duty_ff : day_duty_ff) : off_duty_ff;
      end

      // wait to the coming boundary
      if (cmd.lwait && dv_ff) level_wait_in = {1'b0, level_prod};

      // animation step or load of a new value
      if (cmd.step && step_neg) begin
         if (rolling_ff) begin
            pattern_in    = {socket_of(tens_ff), socket_of(ones_ff)};
            tv_in         = 1'b1;
            tens_in       = (tens_ff == 4'd9) ? 4'd0 : tens_ff + 4'd1;
            ones_in       = (ones_ff == 4'd9) ? 4'd0 : ones_ff + 4'd1;
            steps_left_in = steps_left_ff - 8'sd1;
            if (!roll_end) begin
               step_wait_in = 18'(roll_step_ff);
            end else begin
               rolling_in = 1'b0;
               if (hour_shown_ff) begin
                  step_wait_in = 18'(hour_hold_ff);
               end else begin
                  rem_in     = '0;
                  div_cnt_in = DIV_TOP_BIT;
               end
            end
         end else begin
            if (hour_shown_ff) begin
               tens_in       = min_tens;
               ones_in       = 4'(minute_ff - 6'(min_tens) * 6'd10);
               steps_left_in = ntds_pkg::MINUTE_ROLL_STEPS;
            end else begin
               tens_in       = (hour12 >= 5'd10) ? 4'd1 : 4'd0;
               ones_in       = (hour12 >= 5'd10) ? 4'(hour12 - 5'd10) : hour12[3:0];
               steps_left_in = ntds_pkg::HOUR_ROLL_STEPS;
            end
            hour_shown_in = !hour_shown_ff;
            rolling_in    = 1'b1;
            step_wait_in  = 18'(roll_step_ff);
         end
      end

      // restoring remainder step
      if (cmd.div_step) begin
         rem_in     = (rem_shift >= {1'b0, modulus}) ? 6'(rem_shift - {1'b0, modulus})
                                                    : rem_shift[5:0];
         div_cnt_in = div_cnt_ff - 3'd1;
      end

      // hold to the next multiple of the seconds step
      if (cmd.swait) step_wait_in = {2'b00, hold_prod};
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_wait_ff  <= '0;
         level_wait_ff <= '0;
         tens_ff       <= '0;
         ones_ff       <= '0;
         steps_left_ff <= '0;
         rolling_ff    <= 1'b0;
         hour_shown_ff <= 1'b0;
         tubes_on_ff   <= 1'b1;
         tv_ff         <= 1'b0;
         dv_ff         <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         step_wait_ff  <= step_wait_in;
         level_wait_ff <= level_wait_in;
         tens_ff       <= tens_in;
         ones_ff       <= ones_in;
         steps_left_ff <= steps_left_in;
         rolling_ff    <= rolling_in;
         hour_shown_ff <= hour_shown_in;
         tubes_on_ff   <= tubes_on_in;
         tv_ff         <= tv_in;
         dv_ff         <= dv_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mins_ff    <= mins_in;
      pattern_ff <= pattern_in;
      duty_ff    <= duty_in;
      rem_ff     <= rem_in;
      if (cmd.take) begin
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         second_ff <= req_second;
         now_ff    <= (11'(req_hour) * 11'd60 + 11'(req_minute) >= ntds_pkg::MINUTES_PER_DAY)
                      ? 11'(req_hour) * 11'd60 + 11'(req_minute) - ntds_pkg::MINUTES_PER_DAY
                      : 11'(req_hour) * 11'd60 + 11'(req_minute);
      end
      if (cmd.out_load) begin
         rsp_tube_valid   <= tv_ff;
         rsp_tube_pattern <= pattern_ff;
         rsp_duty_valid   <= dv_ff;
         rsp_duty         <= duty_ff;
      end
   end

   assign status.is_tick     = (req_cmd == ntds_pkg::CMD_TICK);
   assign status.div_needed  = step_neg && roll_end && !hour_shown_ff;
   assign status.div_last    = (div_cnt_ff == 3'd0);
   assign status.have_result = tv_ff || dv_ff;

endmodule

### rtl/nixie_time_display_sequencer_unit.sv
// ----------------------------------------------------------------------------
// nixie_time_display_sequencer_unit - two-tube time display sequencer
// Top level: channels, register port, controller and datapath.
// ----------------------------------------------------------------------------
// A tick passes from acceptance through the brightness, level wait and step
// states to its result entering the output register, and also through the
// remainder and hold states when a minute animation ends; the remainder unit
// finds the hold to the next multiple of the seconds step, resolving one bit
// of the second per cycle. On, off and unused codes are taken in idle state.
// The next item is taken while a result waits in the output register; a tick
// whose result finds it full waits until taken. Registers must be written
// through the csr port only while the block is idle; this is not enforced.
module nixie_time_display_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,
   ntds_req_if.sink                           req_if,
   ntds_rsp_if.source                         rsp_if,
   input  logic                               csr_wr_en,
   input  logic [ntds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ntds_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   ntds_pkg::ntds_cmd_type    cmd;
   ntds_pkg::ntds_status_type status;

   // sequencing and handshakes
   ntds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, waits, digits and output payload
   ntds_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_cmd          (req_if.cmd),
      .req_hour         (req_if.clock_hour),
      .req_minute       (req_if.clock_minute),
      .req_second       (req_if.clock_second),
      .cmd              (cmd),
      .status           (status),
      .rsp_tube_valid   (rsp_if.tube_valid),
      .rsp_tube_pattern (rsp_if.tube_pattern),
      .rsp_duty_valid   (rsp_if.duty_valid),
      .rsp_duty         (rsp_if.duty)
   );

endmodule
